// ===== hdl/dpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_pkg
// Shared types and constants of the dual-port ping-pong mailbox core.
// ----------------------------------------------------------------------------
package dpm_pkg;

    // Geometry. BANK_WORDS is a power of two: word indexes wrap by masking.
    localparam int BOARDS     = 2;
    localparam int BANK_WORDS = 16384;
    localparam int IDX_W      = $clog2(BANK_WORDS);
    localparam int MEM_WORDS  = BOARDS * 2 * BANK_WORDS;
    localparam int MEM_AW     = $clog2(MEM_WORDS);

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_SEL  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_DSP = CFG_IDX_W'(1);

    // Bus access codes
    typedef enum logic [2:0] {
        ACT_HOST_COMM_RD   = 3'd0,
        ACT_HOST_COMM_WR   = 3'd1,
        ACT_HOST_SHARED_RD = 3'd2,
        ACT_HOST_SHARED_WR = 3'd3,
        ACT_DSP_COMM_RD    = 3'd4,
        ACT_DSP_COMM_WR    = 3'd5,
        ACT_DSP_SHARED_RD  = 3'd6,
        ACT_DSP_SHARED_WR  = 3'd7
    } t_action;

    // DSP reset line change
    localparam logic [1:0] RST_NONE    = 2'd0;
    localparam logic [1:0] RST_ASSERT  = 2'd1;
    localparam logic [1:0] RST_RELEASE = 2'd2;

    // Texture half change
    localparam logic [1:0] TEX_NONE  = 2'd0;
    localparam logic [1:0] TEX_LOWER = 2'd1;
    localparam logic [1:0] TEX_UPPER = 2'd2;

    // Control word bits (host comm word 0) and texture select bit (DSP comm word 1)
    localparam int CTL_BANK_BIT    = 24;
    localparam int CTL_IRQ0_BIT    = 25;
    localparam int CTL_IRQ1_BIT    = 26;
    localparam int CTL_RELEASE_BIT = 28;
    localparam int TEX_SEL_BIT     = 3;

    // Where the read data of an item comes from
    typedef enum logic [1:0] {
        SRC_REG   = 2'd0,
        SRC_WORD  = 2'd1,
        SRC_UPPER = 2'd2,
        SRC_LOWER = 2'd3
    } t_rd_src;

    typedef struct packed {
        logic [2:0]  action;
        logic        board;
        logic [14:0] address;
        logic [31:0] write_data;
        logic [3:0]  byte_enable;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  reset_action;
        logic        irq0_pulse;
        logic        irq1_pulse;
        logic        flag_pulse;
        logic [1:0]  texture_half;
        logic        bad_access;
    } t_out_item;

    // Shared memory request
    typedef struct packed {
        logic              re;
        logic [3:0]        we;
        logic [MEM_AW-1:0] addr;
        logic [31:0]       wdata;
    } t_mem_req;

    // Per-item result, waiting for the memory read data
    typedef struct packed {
        logic [31:0] reg_data;
        t_rd_src     src;
        logic [1:0]  reset_action;
        logic        irq0_pulse;
        logic        irq1_pulse;
        logic        flag_pulse;
        logic [1:0]  texture_half;
        logic        bad_access;
    } t_info;

endpackage

// ===== hdl/dpm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_ram
// Single-port synchronous RAM with byte write enables and registered read.
// ----------------------------------------------------------------------------
module dpm_ram #(
    parameter int WORDS  = 65536,
    parameter int ADDR_W = $clog2(WORDS)
) (
    input  logic              i_clk,
    input  logic              i_re,
    input  logic [3:0]        i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [31:0]       i_wdata,
    output logic [31:0]       o_rdata
);

    logic [31:0] r_mem [WORDS];
    logic [31:0] r_rdata;

    // Byte-lane writes
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            if (i_we[i]) begin
                r_mem[i_addr][i*8 +: 8] <= i_wdata[i*8 +: 8];
            end
        end
    end

    // Registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/dpm_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_decode
// Access decode, comm word and bank registers, configuration registers.
// ----------------------------------------------------------------------------
module dpm_decode (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  dpm_pkg::t_in_item                i_item,
    input  logic                             i_cfg_write,
    input  logic [dpm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic                             i_cfg_data,
    output dpm_pkg::t_mem_req                o_mem_req,
    output dpm_pkg::t_info                   o_info
);
    import dpm_pkg::*;

    logic        r_tex_en;
    logic        r_flag_en;
    logic        r_bank     [BOARDS];
    logic [7:0]  r_h2d0     [BOARDS];
    logic [31:0] r_h2d1     [BOARDS];
    logic [31:0] r_d2h      [BOARDS][2];

    logic                b_ok;
    logic                bank;
    logic                comm_ok;
    logic [IDX_W+14:0]   h_ext;
    logic [IDX_W+14:0]   d_ext;
    logic [IDX_W-1:0]    hidx;
    logic [IDX_W-1:0]    didx;
    logic [31:0]         h2d_rd;
    logic                w_bank;
    logic                w_h2d0;
    logic                w_h2d1;
    logic                w_d2h;

    assign b_ok    = (32'(i_item.board) < BOARDS);
    assign bank    = r_bank[i_item.board];
    assign comm_ok = (i_item.address[14:1] == 14'd0);
    assign h_ext   = {{IDX_W{1'b0}}, i_item.address};
    assign d_ext   = {{IDX_W{1'b0}}, 1'b0, i_item.address[14:1]};
    assign hidx    = h_ext[IDX_W-1:0];
    assign didx    = d_ext[IDX_W-1:0];
    assign h2d_rd  = i_item.address[0] ? r_h2d1[i_item.board]
                                       : {24'd0, r_h2d0[i_item.board]};

    // Access decode
    always_comb begin
        o_info    = '0;
        o_mem_req = '0;
        o_info.src = SRC_REG;
        o_mem_req.wdata = i_item.write_data;
        w_bank = 1'b0;
        w_h2d0 = 1'b0;
        w_h2d1 = 1'b0;
        w_d2h  = 1'b0;
        if (b_ok) begin
            unique case (t_action'(i_item.action))
                ACT_HOST_COMM_RD: begin
                    if (comm_ok) begin
                        o_info.reg_data = r_d2h[i_item.board][i_item.address[0]];
                    end
                end
                ACT_HOST_COMM_WR: begin
                    if (i_item.address == 15'd0) begin
                        if (i_item.byte_enable[3]) begin
                            o_info.reset_action = i_item.write_data[CTL_RELEASE_BIT]
                                                  ? RST_RELEASE : RST_ASSERT;
                            o_info.irq0_pulse = i_item.write_data[CTL_IRQ0_BIT];
                            o_info.irq1_pulse = i_item.write_data[CTL_IRQ1_BIT];
                            w_bank = 1'b1;
                        end
                        w_h2d0 = i_item.byte_enable[0];
                    end else if (i_item.address == 15'd1) begin
                        w_h2d1 = 1'b1;
                    end
                end
                ACT_HOST_SHARED_RD: begin
                    o_mem_req.re   = 1'b1;
                    o_mem_req.addr = MEM_AW'({i_item.board, bank, hidx});
                    o_info.src     = SRC_WORD;
                end
                ACT_HOST_SHARED_WR: begin
                    o_mem_req.we   = i_item.byte_enable;
                    o_mem_req.addr = MEM_AW'({i_item.board, bank, hidx});
                end
                ACT_DSP_COMM_RD: begin
                    if (comm_ok) begin
                        o_info.reg_data = h2d_rd;
                    end
                end
                ACT_DSP_COMM_WR: begin
                    if (!comm_ok) begin
                        o_info.bad_access = 1'b1;
                    end else begin
                        if (i_item.address[0] && r_tex_en) begin
                            o_info.texture_half = i_item.write_data[TEX_SEL_BIT]
                                                  ? TEX_UPPER : TEX_LOWER;
                        end
                        o_info.flag_pulse = r_flag_en;
                        w_d2h = 1'b1;
                    end
                end
                ACT_DSP_SHARED_RD: begin
                    o_mem_req.re   = 1'b1;
                    o_mem_req.addr = MEM_AW'({i_item.board, ~bank, didx});
                    o_info.src     = i_item.address[0] ? SRC_LOWER : SRC_UPPER;
                end
                ACT_DSP_SHARED_WR: begin
                    // odd half index: bits 15..0, even: bits 31..16
                    o_mem_req.we    = i_item.address[0] ? 4'b0011 : 4'b1100;
                    o_mem_req.addr  = MEM_AW'({i_item.board, ~bank, didx});
                    o_mem_req.wdata = {i_item.write_data[15:0], i_item.write_data[15:0]};
                end
            endcase
        end
        // no memory access unless the item is taken
        if (!i_accept) begin
            o_mem_req.re = 1'b0;
            o_mem_req.we = 4'b0000;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_en  <= 1'b0;
            r_flag_en <= 1'b0;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_TEX_SEL:  r_tex_en  <= i_cfg_data;
                CFG_FLAG_DSP: r_flag_en <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Comm words and bank bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BOARDS; b++) begin
                r_bank[b]   <= 1'b0;
                r_h2d0[b]   <= 8'd0;
                r_h2d1[b]   <= 32'd0;
                r_d2h[b][0] <= 32'd0;
                r_d2h[b][1] <= 32'd0;
            end
        end else if (i_accept) begin
            if (w_bank) begin
                r_bank[i_item.board] <= i_item.write_data[CTL_BANK_BIT];
            end
            if (w_h2d0) begin
                r_h2d0[i_item.board] <= i_item.write_data[7:0];
            end
            if (w_h2d1) begin
                r_h2d1[i_item.board] <= i_item.write_data;
            end
            if (w_d2h) begin
                r_d2h[i_item.board][i_item.address[0]] <= i_item.write_data;
            end
        end
    end

endmodule

// ===== hdl/dual_port_pingpong_mailbox_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_port_pingpong_mailbox_core
// Host/DSP mailbox with comm words and a ping-pong shared memory per board.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one bus access per item (host or DSP, comm word or shared
//   memory, read or write), taken when i_in_valid is high and o_in_stall low.
//   Output channel: exactly one result item per access; the receiver holds
//   i_out_stall high to keep the current result on o_out_item.
//   Config channel: i_cfg_valid/o_cfg_ready write of the texture-select and
//   DSP-flag enables; o_cfg_ready is always high. Write only while idle.
// Timing:
//   The accepting edge registers the shared memory read and the item info in
//   the memory stage; the output register loads from there once it is free
//   (o_out_valid or i_out_stall low). One item per cycle is sustained while
//   i_out_stall stays low; all state updates land at the accept edge, so
//   back-to-back accesses to the same word see each other's writes.
// Reset:
//   Synchronous, active low. Clears comm words, bank bits, config enables and
//   the pipeline valids. Shared memory content is undefined until written.
// Stall:
//   A stalled result stays in the output register; one more item can wait in
//   the memory stage, after which o_in_stall rises.
// ----------------------------------------------------------------------------
module dual_port_pingpong_mailbox_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dpm_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dpm_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                          i_cfg_data
);
    import dpm_pkg::*;

    logic       accept;
    logic       a_ready;
    logic       a_move;
    t_mem_req   mem_req;
    t_info      info;
    logic [31:0] ram_q;

    logic       r_a_valid;
    t_info      r_a;
    logic       r_o_valid;
    t_out_item  r_o_item;
    t_out_item  n_o_item;

    assign a_ready     = !r_o_valid || !i_out_stall;
    assign a_move      = r_a_valid && a_ready;
    assign o_in_stall  = r_a_valid && !a_ready;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    dpm_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mem_req   (mem_req),
        .o_info      (info)
    );

    dpm_ram #(
        .WORDS  (MEM_WORDS),
        .ADDR_W (MEM_AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_re    (mem_req.re),
        .i_we    (mem_req.we),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (ram_q)
    );

    // Memory stage: item waits here for the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= info;
        end
    end

    // Result assembly
    always_comb begin
        n_o_item.reset_action = r_a.reset_action;
        n_o_item.irq0_pulse   = r_a.irq0_pulse;
        n_o_item.irq1_pulse   = r_a.irq1_pulse;
        n_o_item.flag_pulse   = r_a.flag_pulse;
        n_o_item.texture_half = r_a.texture_half;
        n_o_item.bad_access   = r_a.bad_access;
        case (r_a.src)
            SRC_WORD:  n_o_item.read_data = ram_q;
            SRC_UPPER: n_o_item.read_data = {16'd0, ram_q[31:16]};
            SRC_LOWER: n_o_item.read_data = {16'd0, ram_q[15:0]};
            default:   n_o_item.read_data = r_a.reg_data;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_move) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_o_item <= n_o_item;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

endmodule

// ===== hdl/dpm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_checker
// Port-level assertions for the mailbox core, bound to the top level.
// ----------------------------------------------------------------------------
module dpm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  dpm_pkg::t_out_item            o_out_item
);
    import dpm_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // IRQ pulses only come with a control word write, which always moves reset
    a_irq_with_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.irq0_pulse || o_out_item.irq1_pulse)
        |-> o_out_item.reset_action != RST_NONE)
        else $error("irq pulse without control word write");

    // A rejected DSP comm write has no other effect
    a_bad_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.bad_access
        |-> o_out_item.read_data == 32'd0 && !o_out_item.flag_pulse &&
            o_out_item.texture_half == TEX_NONE &&
            o_out_item.reset_action == RST_NONE)
        else $error("bad access with side effects");

    // Texture change only on a good DSP comm write
    a_tex_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.texture_half != TEX_NONE
        |-> o_out_item.read_data == 32'd0 && !o_out_item.bad_access &&
            o_out_item.reset_action == RST_NONE)
        else $error("texture change on wrong access");

endmodule

bind dual_port_pingpong_mailbox_core dpm_checker u_dpm_checker (.*);

// ===== tb/sv/mailbox_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mailbox_checker
// Watches the access, result and config channels of the mailbox core, keeps
// its own image of comm words, bank bits, enables and shared memory, predicts
// one result per accepted access and compares results in order.
// ----------------------------------------------------------------------------
module mailbox_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  dpm_pkg::t_in_item             i_in_item,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  dpm_pkg::t_out_item            i_out_item,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [dpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                          i_cfg_data,
    output int                            o_pending,
    output int                            o_mismatches
);
    import dpm_pkg::*;

    localparam int REPORT_MAX = 10;

    // Mailbox image
    logic [31:0] host_words [0:1][0:1];
    logic [31:0] dsp_words  [0:1][0:1];
    logic [1:0]  bank_bits;
    logic        tex_enable;
    logic        flag_enable;
    logic [31:0] shared_words [0:4*BANK_WORDS-1];

    t_out_item   expected_results [$];
    int          pending_count = 0;
    int          mismatch_count = 0;

    assign o_pending    = pending_count;
    assign o_mismatches = mismatch_count;

    // Result of one access, updating the image as the block does
    function automatic t_out_item mailbox_access_result(t_in_item it);
        t_out_item   r;
        logic        bank;
        logic [15:0] host_key;
        logic [15:0] dsp_key;
        logic [31:0] lanes;
        r        = '0;
        bank     = bank_bits[it.board];
        host_key = {it.board, bank, it.address[IDX_W-1:0]};
        dsp_key  = {it.board, ~bank, it.address[IDX_W:1]};
        lanes    = {{8{it.byte_enable[3]}}, {8{it.byte_enable[2]}},
                    {8{it.byte_enable[1]}}, {8{it.byte_enable[0]}}};
        case (it.action)
            ACT_HOST_COMM_RD: begin
                if (it.address < 2)
                    r.read_data = dsp_words[it.board][it.address[0]];
            end
            ACT_HOST_COMM_WR: begin
                if (it.address == 0) begin
                    // control word: lane 3 carries reset, IRQs and bank bit
                    if (it.byte_enable[3]) begin
                        r.reset_action = it.write_data[CTL_RELEASE_BIT] ? RST_RELEASE
                                                                         : RST_ASSERT;
                        r.irq0_pulse   = it.write_data[CTL_IRQ0_BIT];
                        r.irq1_pulse   = it.write_data[CTL_IRQ1_BIT];
                        bank_bits[it.board] = it.write_data[CTL_BANK_BIT];
                    end
                    if (it.byte_enable[0])
                        host_words[it.board][0] = {24'h0, it.write_data[7:0]};
                end else if (it.address == 1) begin
                    host_words[it.board][1] = it.write_data;
                end
            end
            ACT_HOST_SHARED_RD: r.read_data = shared_words[host_key];
            ACT_HOST_SHARED_WR: begin
                shared_words[host_key] = (shared_words[host_key] & ~lanes)
                                       | (it.write_data & lanes);
            end
            ACT_DSP_COMM_RD: begin
                if (it.address < 2)
                    r.read_data = host_words[it.board][it.address[0]];
            end
            ACT_DSP_COMM_WR: begin
                if (it.address >= 2) begin
                    r.bad_access = 1'b1;
                end else begin
                    if (it.address == 1 && tex_enable)
                        r.texture_half = it.write_data[TEX_SEL_BIT] ? TEX_UPPER : TEX_LOWER;
                    r.flag_pulse = flag_enable;
                    dsp_words[it.board][it.address[0]] = it.write_data;
                end
            end
            ACT_DSP_SHARED_RD: begin
                // odd half index is the low half of the word
                r.read_data = it.address[0] ? {16'h0, shared_words[dsp_key][15:0]}
                                            : {16'h0, shared_words[dsp_key][31:16]};
            end
            default: begin
                if (it.address[0])
                    shared_words[dsp_key][15:0] = it.write_data[15:0];
                else
                    shared_words[dsp_key][31:16] = it.write_data[15:0];
            end
        endcase
        return r;
    endfunction

    // Compare on the result channel, predict on the access channel
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            host_words[0][0] = '0;
            host_words[0][1] = '0;
            host_words[1][0] = '0;
            host_words[1][1] = '0;
            dsp_words[0][0]  = '0;
            dsp_words[0][1]  = '0;
            dsp_words[1][0]  = '0;
            dsp_words[1][1]  = '0;
            bank_bits        = '0;
            tex_enable       = 1'b0;
            flag_enable      = 1'b0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: result with none expected, rd=%h", $time,
                                 i_out_item.read_data);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_item.read_data    !== want.read_data    ||
                        i_out_item.reset_action !== want.reset_action ||
                        i_out_item.irq0_pulse   !== want.irq0_pulse   ||
                        i_out_item.irq1_pulse   !== want.irq1_pulse   ||
                        i_out_item.flag_pulse   !== want.flag_pulse   ||
                        i_out_item.texture_half !== want.texture_half ||
                        i_out_item.bad_access   !== want.bad_access) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("%0t: mismatch exp rd=%h rst=%0d irq=%b%b flag=%b",
                                     $time, want.read_data, want.reset_action,
                                     want.irq0_pulse, want.irq1_pulse, want.flag_pulse,
                                     " tex=%0d bad=%b,", want.texture_half,
                                     want.bad_access,
                                     " got rd=%h rst=%0d irq=%b%b flag=%b",
                                     i_out_item.read_data, i_out_item.reset_action,
                                     i_out_item.irq0_pulse, i_out_item.irq1_pulse,
                                     i_out_item.flag_pulse,
                                     " tex=%0d bad=%b", i_out_item.texture_half,
                                     i_out_item.bad_access);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TEX_SEL:  tex_enable  = i_cfg_data;
                    CFG_FLAG_DSP: flag_enable = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(mailbox_access_result(i_in_item));
        end
        pending_count = expected_results.size();
    end

endmodule

// ===== tb/sv/tb_dual_port_pingpong_mailbox_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_port_pingpong_mailbox_core
// Drives host and DSP accesses into the mailbox core: a directed pass over
// control word, comm words, bank switching and shared memory halves, then
// random traffic in phases with different enable settings, bursty input and
// random output stall. The checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module tb_dual_port_pingpong_mailbox_core;
    import dpm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 140;
    localparam int POOL_SIZE   = 12;
    localparam int LONG_HOLD   = 60;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_item             in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic                 cfg_data = 1'b0;

    int                   pending;
    int                   mismatches;
    int                   cycle_count = 0;
    int                   hold_requests = 0;

    // Stimulus view: bank bits and written byte lanes, so that no shared
    // entry is read before it was written
    logic [1:0]           bank_view = '0;
    logic [3:0]           lanes_written [int];
    logic [IDX_W-1:0]     word_pool [POOL_SIZE];

    dual_port_pingpong_mailbox_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mailbox_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_dual_port_pingpong_mailbox_core NOT OK");
        $finish;
    end

    // Receiver stall: random modes, plus a long hold-off on request
    initial begin
        int hold_left;
        int hold_seen;
        int mode_left;
        int mode;
        hold_left = 0;
        hold_seen = 0;
        mode_left = 0;
        mode      = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (hold_requests != hold_seen && hold_left == 0) begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= (mode_left % 4 == 0);
                endcase
            end
        end
    end

    function automatic t_in_item access(t_action act, logic brd, logic [14:0] addr,
                                        logic [31:0] data, logic [3:0] be);
        t_in_item it;
        it.action      = act;
        it.board       = brd;
        it.address     = addr;
        it.write_data  = data;
        it.byte_enable = be;
        return it;
    endfunction

    function automatic int host_key(t_in_item it);
        return int'({it.board, bank_view[it.board], it.address[IDX_W-1:0]});
    endfunction

    function automatic int dsp_key(t_in_item it);
        return int'({it.board, ~bank_view[it.board], it.address[IDX_W:1]});
    endfunction

    function automatic logic [3:0] lanes_of(int key);
        return lanes_written.exists(key) ? lanes_written[key] : 4'b0000;
    endfunction

    // Keep the stimulus view in step with the order of items sent
    function automatic void track_access(t_in_item it);
        int k;
        case (it.action)
            ACT_HOST_COMM_WR: begin
                if (it.address == 0 && it.byte_enable[3])
                    bank_view[it.board] = it.write_data[CTL_BANK_BIT];
            end
            ACT_HOST_SHARED_WR: begin
                k = host_key(it);
                lanes_written[k] = lanes_of(k) | it.byte_enable;
            end
            ACT_DSP_SHARED_WR: begin
                k = dsp_key(it);
                lanes_written[k] = lanes_of(k) | (it.address[0] ? 4'b0011 : 4'b1100);
            end
            default: ;
        endcase
    endfunction

    // Random access; a read of lanes never written becomes a write
    function automatic t_in_item random_access();
        t_in_item         it;
        logic [IDX_W-1:0] word;
        int               pick;
        it.action      = t_action'($urandom_range(0, 7));
        it.board       = 1'($urandom_range(0, 1));
        it.write_data  = $urandom;
        it.byte_enable = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) == 0)
            word = IDX_W'($urandom_range(0, BANK_WORDS - 1));
        else
            word = word_pool[$urandom_range(0, POOL_SIZE - 1)];
        pick = $urandom_range(0, 9);
        case (it.action)
            ACT_HOST_SHARED_RD, ACT_HOST_SHARED_WR:
                it.address = {1'($urandom_range(0, 1)), word};
            ACT_DSP_SHARED_RD, ACT_DSP_SHARED_WR:
                it.address = {word, 1'($urandom_range(0, 1))};
            default: begin
                if (pick < 8)
                    it.address = 15'($urandom_range(0, 1));
                else if (pick == 8)
                    it.address = 15'($urandom_range(2, 7));
                else
                    it.address = 15'($urandom_range(0, 32767));
            end
        endcase
        if (it.action == ACT_HOST_SHARED_RD && lanes_of(host_key(it)) != 4'b1111) begin
            it.action      = ACT_HOST_SHARED_WR;
            it.byte_enable = 4'b1111;
        end
        if (it.action == ACT_DSP_SHARED_RD &&
            (lanes_of(dsp_key(it)) & (it.address[0] ? 4'b0011 : 4'b1100)) !=
            (it.address[0] ? 4'b0011 : 4'b1100))
            it.action = ACT_DSP_SHARED_WR;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        track_access(it);
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic sender_gap(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            in_item  <= t_in_item'({$urandom, $urandom});
        end
    endtask

    // Drop valid and wait until every expected result has come
    task automatic wait_idle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_enables(input logic tex_en, input logic flag_en);
        write_cfg(CFG_TEX_SEL, tex_en);
        write_cfg(CFG_FLAG_DSP, flag_en);
    endtask

    // Bursts of random length with random gaps
    task automatic run_random(input int count);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 2) != 0)
                    sender_gap($urandom_range(1, 6));
            end
            send_item(random_access());
            burst--;
        end
    endtask

    task automatic run_directed();
        // comm reads from reset, index above 1
        send_item(access(ACT_HOST_COMM_RD, 1'b0, 15'd0, 32'h0, 4'h0));
        send_item(access(ACT_HOST_COMM_RD, 1'b1, 15'd1, 32'h0, 4'h0));
        send_item(access(ACT_DSP_COMM_RD, 1'b0, 15'd2, 32'h0, 4'h0));
        // word 1 ignores byte enables; control word lanes
        send_item(access(ACT_HOST_COMM_WR, 1'b0, 15'd1, 32'hDEADBEEF, 4'h0));
        send_item(access(ACT_HOST_COMM_WR, 1'b0, 15'd0, 32'h170000A5, 4'hF));
        send_item(access(ACT_HOST_COMM_WR, 1'b0, 15'd0, 32'hFFFFFFFF, 4'h6));
        send_item(access(ACT_HOST_COMM_WR, 1'b0, 15'd0, 32'h00000000, 4'h8));
        send_item(access(ACT_DSP_COMM_RD, 1'b0, 15'd0, 32'h0, 4'h0));
        send_item(access(ACT_DSP_COMM_RD, 1'b0, 15'd1, 32'h0, 4'h0));
        // DSP comm writes: flag, texture upper/lower, bad index
        send_item(access(ACT_DSP_COMM_WR, 1'b0, 15'd0, 32'hFFFFFFFF, 4'h0));
        send_item(access(ACT_DSP_COMM_WR, 1'b0, 15'd1, 32'h00000008, 4'h0));
        send_item(access(ACT_DSP_COMM_WR, 1'b0, 15'd1, 32'hFFFFFFF7, 4'hF));
        send_item(access(ACT_DSP_COMM_WR, 1'b1, 15'd2, 32'h12345678, 4'h0));
        send_item(access(ACT_DSP_COMM_WR, 1'b1, 15'd32767, 32'hFFFFFFFF, 4'hF));
        send_item(access(ACT_HOST_COMM_RD, 1'b0, 15'd1, 32'h0, 4'h0));
        // host words, partial lanes, wrap past the bank end
        send_item(access(ACT_HOST_SHARED_WR, 1'b0, 15'd0, 32'h12345678, 4'hF));
        send_item(access(ACT_HOST_SHARED_WR, 1'b0, 15'h3FFF, 32'hFFFFFFFF, 4'hF));
        send_item(access(ACT_HOST_SHARED_WR, 1'b0, 15'h3FFF, 32'h00000000, 4'h5));
        send_item(access(ACT_HOST_SHARED_RD, 1'b0, 15'h7FFF, 32'h0, 4'h0));
        // DSP halves of the other bank
        send_item(access(ACT_DSP_SHARED_WR, 1'b0, 15'd0, 32'hFFFFABCD, 4'h0));
        send_item(access(ACT_DSP_SHARED_WR, 1'b0, 15'd1, 32'h00001234, 4'h0));
        send_item(access(ACT_DSP_SHARED_RD, 1'b0, 15'd0, 32'h0, 4'h0));
        send_item(access(ACT_DSP_SHARED_RD, 1'b0, 15'd1, 32'h0, 4'h0));
        // swap banks and read back from both sides
        send_item(access(ACT_HOST_COMM_WR, 1'b0, 15'd0, 32'h01000000, 4'h8));
        send_item(access(ACT_HOST_SHARED_RD, 1'b0, 15'd0, 32'h0, 4'h0));
        send_item(access(ACT_DSP_SHARED_RD, 1'b0, 15'd0, 32'h0, 4'h0));
        send_item(access(ACT_DSP_SHARED_RD, 1'b0, 15'd1, 32'h0, 4'h0));
    endtask

    // Main sequence
    initial begin
        word_pool[0] = '0;
        word_pool[1] = IDX_W'(1);
        word_pool[2] = IDX_W'(BANK_WORDS - 1);
        word_pool[3] = IDX_W'(BANK_WORDS - 2);
        for (int p = 4; p < POOL_SIZE; p++)
            word_pool[p] = IDX_W'($urandom_range(0, BANK_WORDS - 1));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_enables(1'b1, 1'b1);
        run_directed();

        // long receiver hold while the sender keeps going
        wait_idle();
        set_enables(1'b0, 1'b0);
        hold_requests++;
        run_random(PHASE_ITEMS);

        // sender pauses mid-phase until drained
        wait_idle();
        set_enables(1'b1, 1'b0);
        run_random(PHASE_ITEMS / 2);
        wait_idle();
        run_random(PHASE_ITEMS / 2);

        wait_idle();
        set_enables(1'b0, 1'b1);
        hold_requests++;
        run_random(PHASE_ITEMS);

        wait_idle();
        set_enables(1'b1, 1'b1);
        run_random(PHASE_ITEMS);

        wait_idle();
        set_enables(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        run_random(PHASE_ITEMS);

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_dual_port_pingpong_mailbox_core OK");
        end else begin
            $display("tb_dual_port_pingpong_mailbox_core NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/dpm_pkg.sv
hdl/dpm_ram.sv
hdl/dpm_decode.sv
hdl/dual_port_pingpong_mailbox_core.sv
hdl/dpm_checker.sv
tb/sv/mailbox_checker.sv
tb/sv/tb_dual_port_pingpong_mailbox_core.sv
